// ===== sv/mst_pkg.sv =====
// Shared types and constants for the MRU site table.
// No dependencies; every other file in this folder uses it.
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int PPM_BITS     = 16;

  typedef enum logic [1:0] {
    REQ_TOUCH  = 2'd0,
    REQ_SET    = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MATCH  = 2'd1,
    ST_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mst_cell.sv =====
// One table cell: holds a key and its correction, compares against the
// broadcast key and takes its neighbor's entry when told to shift.
// Depends on mst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mst_cell #(
  parameter int KEY_BITS = mst_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire mst_pkg::cell_ctl_t               ctl,
  input  wire logic                             occupied,
  input  wire logic [KEY_BITS-1:0]              cmp_key,
  input  wire logic [KEY_BITS-1:0]              nb_key,
  input  wire logic signed [mst_pkg::PPM_BITS-1:0] nb_ppm,
  output logic [KEY_BITS-1:0]                   key,
  output logic signed [mst_pkg::PPM_BITS-1:0]   ppm,
  output logic                                  match
);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= occupied && (key == cmp_key);
    end
    if (ctl.shift) begin
      key <= nb_key;
      ppm <= nb_ppm;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mru_site_table_with_correction.sv =====
// Top level of the MRU site table: a row of cells plus request control.
// Depends on mst_pkg and mst_cell.
`timescale 1ns / 1ps
`default_nettype none

// Most-recently-used table of keyed entries with a signed correction each.
// Every word passes three steps: ST_IDLE accepts it, in ST_MATCH every cell
// compares its key, and in ST_UPDATE the cells shift toward the back and
// the result word is loaded; the input stalls until the table is idle again.
// The result word waits in an output register, and the next word is
// accepted while it does. While an earlier result still waits under stall,
// the ST_UPDATE step of the next word is held until that result is taken.
// A key of zero or request type 3 changes nothing and returns all zeros.

module mru_site_table_with_correction #(
  parameter int ENTRIES  = mst_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mst_pkg::KEY_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          req_type,
  input  wire logic [KEY_BITS-1:0]                 key,
  input  wire logic signed [mst_pkg::PPM_BITS-1:0] ppm_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     changed,
  output logic signed [mst_pkg::PPM_BITS-1:0]      ppm_out,
  output logic                                     was_present
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = mst_pkg::PPM_BITS;

  mst_pkg::state_t state, state_next;
  mst_pkg::req_t   req_q;
  logic [KEY_BITS-1:0] key_q;
  logic signed [PW-1:0] val_q;
  logic active;
  logic [CW-1:0] fill_count;

  logic [KEY_BITS-1:0]  cell_key [ENTRIES];
  logic signed [PW-1:0] cell_ppm [ENTRIES];
  logic [ENTRIES-1:0]   match;
  mst_pkg::cell_ctl_t   ctl [ENTRIES];

  logic accept, capture, finish, do_update, hit;
  logic signed [PW-1:0] carried, front_ppm, res_ppm;
  logic res_changed;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    capture    = 1'b0;
    finish     = 1'b0;
    unique case (state)
      mst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = mst_pkg::ST_MATCH;
        end
      end
      mst_pkg::ST_MATCH: begin
        capture    = 1'b1;
        state_next = mst_pkg::ST_UPDATE;
      end
      mst_pkg::ST_UPDATE: begin
        if (!out_valid || !out_stall) begin
          finish     = 1'b1;
          state_next = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= mst_pkg::req_t'(req_type);
      key_q  <= key;
      val_q  <= ppm_in;
      active <= (key != '0) && (mst_pkg::req_t'(req_type) != mst_pkg::REQ_NONE);
    end
  end

  always_comb begin
    hit     = |match;
    carried = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      carried = carried | (cell_ppm[i] & {PW{match[i]}});
    end
  end

  always_comb begin
    do_update   = 1'b0;
    front_ppm   = carried;
    res_changed = 1'b0;
    res_ppm     = '0;
    if (active) begin
      unique case (req_q)
        mst_pkg::REQ_TOUCH: begin
          do_update   = 1'b1;
          front_ppm   = hit ? carried : '0;
          res_changed = !hit;
        end
        mst_pkg::REQ_SET: begin
          do_update   = 1'b1;
          front_ppm   = val_q;
          res_changed = (hit ? carried : '0) != val_q;
        end
        mst_pkg::REQ_LOOKUP: begin
          res_ppm = hit ? carried : '0;
        end
        default: begin
          do_update = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    always_comb begin
      ctl[i].capture = capture;
      if (i == 0) begin
        ctl[i].shift = finish && do_update;
      end else begin
        ctl[i].shift = finish && do_update &&
                       (hit ? (|match[ENTRIES-1:i]) : (fill_count >= CW'(i)));
      end
    end

    mst_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl[i]),
      .occupied(fill_count > CW'(i)),
      .cmp_key (key_q),
      .nb_key  ((i == 0) ? key_q : cell_key[(i == 0) ? 0 : i-1]),
      .nb_ppm  ((i == 0) ? front_ppm : cell_ppm[(i == 0) ? 0 : i-1]),
      .key     (cell_key[i]),
      .ppm     (cell_ppm[i]),
      .match   (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (finish && do_update && !hit && (fill_count < CW'(ENTRIES))) begin
        fill_count <= fill_count + CW'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      changed     <= res_changed;
      ppm_out     <= res_ppm;
      was_present <= active && hit;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_mru_site_table_with_correction.sv =====
// Testbench for mru_site_table_with_correction: a self-checking bench that runs
// directed and random request words and checks every result against its own table model.
// Depends on mst_pkg and the RTL of the table.
`timescale 1ns / 1ps

module tb_mru_site_table_with_correction;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LIVE_WORDS  = 1700;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    mst_pkg::req_t      req;
    logic [63:0]        key;
    logic signed [15:0] ppm;
    int                 gap;
    bit                 drain;
  } site_word_t;

  typedef struct packed {
    logic               changed;
    logic signed [15:0] ppm;
    logic               present;
  } site_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type = '0;
  logic [63:0]         key = '0;
  logic signed [15:0]  ppm_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                changed;
  logic signed [15:0]  ppm_out;
  logic                was_present;

  site_word_t          word_q[$];
  site_result_t        expected_q[$];
  site_word_t          cur_word;
  int                  gap_left = 0;
  int                  stall_left = 0;
  int                  cycle_count = 0;
  int                  mismatch_count = 0;

  logic [63:0]         shadow_keys[mst_pkg::ENTRIES_DEF];
  logic signed [15:0]  shadow_ppm[mst_pkg::ENTRIES_DEF];
  int                  shadow_fill = 0;

  mru_site_table_with_correction i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key),
    .ppm_in      (ppm_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .changed     (changed),
    .ppm_out     (ppm_out),
    .was_present (was_present)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit move_to_front(logic [63:0] k, int slot);
    logic signed [15:0] carried;
    int i;
    if (slot == 0) return 1'b0;
    if (slot > 0) begin
      carried = shadow_ppm[slot];
      for (i = slot; i > 0; i--) begin
        shadow_keys[i] = shadow_keys[i-1];
        shadow_ppm[i]  = shadow_ppm[i-1];
      end
      shadow_keys[0] = k;
      shadow_ppm[0]  = carried;
      return 1'b0;
    end
    if (shadow_fill < mst_pkg::ENTRIES_DEF) shadow_fill++;
    for (i = shadow_fill - 1; i > 0; i--) begin
      shadow_keys[i] = shadow_keys[i-1];
      shadow_ppm[i]  = shadow_ppm[i-1];
    end
    shadow_keys[0] = k;
    shadow_ppm[0]  = '0;
    return 1'b1;
  endfunction

  function automatic site_result_t predict_site_result(site_word_t w);
    site_result_t r;
    int slot;
    int i;
    r = '0;
    if (w.key == '0 || w.req == mst_pkg::REQ_NONE) return r;
    slot = -1;
    for (i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_keys[i] == w.key) slot = i;
    end
    r.present = (slot >= 0);
    case (w.req)
      mst_pkg::REQ_TOUCH: begin
        r.changed = move_to_front(w.key, slot);
      end
      mst_pkg::REQ_SET: begin
        void'(move_to_front(w.key, slot));
        if (shadow_ppm[0] != w.ppm) begin
          shadow_ppm[0] = w.ppm;
          r.changed = 1'b1;
        end
      end
      default: begin
        if (slot >= 0) r.ppm = shadow_ppm[slot];
      end
    endcase
    return r;
  endfunction

  function automatic void push_word(mst_pkg::req_t r, logic [63:0] k, logic signed [15:0] p,
                                    int gap, bit drain);
    site_word_t w;
    w.req   = r;
    w.key   = k;
    w.ppm   = p;
    w.gap   = gap;
    w.drain = drain;
    word_q.push_back(w);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_site_result(cur_word));
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_q.size() > 0 && (!word_q[0].drain || expected_q.size() == 0)) begin
        cur_word = word_q.pop_front();
        in_valid <= 1'b1;
        req_type <= cur_word.req;
        key      <= cur_word.key;
        ppm_in   <= cur_word.ppm;
        gap_left <= cur_word.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    site_result_t exp_r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result word: changed=%0d ppm=%0d present=%0d",
                     changed, ppm_out, was_present);
          end
          mismatch_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (changed !== exp_r.changed || ppm_out !== exp_r.ppm ||
              was_present !== exp_r.present) begin
            if (mismatch_count < 10) begin
              $write("result mismatch: expected changed=%0d ppm=%0d present=%0d,",
                     exp_r.changed, $signed(exp_r.ppm), exp_r.present);
              $display(" got changed=%0d ppm=%0d present=%0d",
                       changed, ppm_out, was_present);
            end
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if ((cycle_count % 4096) < 1024) stall_left <= 0;
        else stall_left <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_mru_site_table_with_correction: FAIL");
      $finish;
    end
  end

  initial begin
    logic [63:0]        key_pool[POOL_SIZE];
    logic [63:0]        k;
    logic [63:0]        last_set_key;
    logic signed [15:0] p;
    logic signed [15:0] last_set_ppm;
    mst_pkg::req_t      r;
    int                 live;
    int                 n;
    int                 i;
    int                 sel;
    int                 gap;
    bit                 drain;

    push_word(mst_pkg::REQ_LOOKUP, 64'h0123_4567_89ab_cdef, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_TOUCH, 64'd0, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'd0, 16'sd5, 1, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'd0, -16'sd1, 0, 1'b0);
    push_word(mst_pkg::REQ_NONE, 64'h0123_4567_89ab_cdef, 16'sd7, 0, 1'b0);
    push_word(mst_pkg::REQ_TOUCH, 64'h0123_4567_89ab_cdef, 16'sd0, 2, 1'b0);
    push_word(mst_pkg::REQ_TOUCH, 64'h0123_4567_89ab_cdef, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'h0123_4567_89ab_cdef, 16'sh7fff, 0, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'h0123_4567_89ab_cdef, 16'sh7fff, 0, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'h0123_4567_89ab_cdef, 16'sd0, 3, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'hffff_ffff_ffff_ffff, -16'sd32768, 0, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'h8000_0000_0000_0000, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_TOUCH, 64'h0123_4567_89ab_cdef, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_SET, 64'hffff_ffff_ffff_ffff, 16'sd0, 1, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0000, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_TOUCH, 64'd1, -16'sd1, 0, 1'b0);
    push_word(mst_pkg::REQ_NONE, 64'hffff_ffff_ffff_ffff, -16'sd1, 0, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'd1, 16'sd0, 0, 1'b0);
    push_word(mst_pkg::REQ_LOOKUP, 64'h0123_4567_89ab_cdef, 16'sd0, 0, 1'b0);

    live = 0;
    n = 0;
    last_set_key = 64'd1;
    last_set_ppm = 16'sd0;
    while (live < LIVE_WORDS) begin
      if (n % 400 == 0) begin
        for (i = 0; i < POOL_SIZE; i++) begin
          key_pool[i] = {$urandom, $urandom};
          if (key_pool[i] == '0) key_pool[i] = 64'd1;
        end
      end
      drain = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        p = 16'sh7fff;
      end else if (sel < 6) begin
        p = -16'sd32768;
      end else if (sel < 20) begin
        p = 16'($urandom_range(0, 2) - 1);
      end else begin
        p = 16'($urandom);
      end
      sel = $urandom_range(0, 99);
      if (sel < 35) r = mst_pkg::REQ_TOUCH;
      else if (sel < 70) r = mst_pkg::REQ_SET;
      else r = mst_pkg::REQ_LOOKUP;
      sel = $urandom_range(0, 99);
      if (sel < 80) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (sel < 92) k = {$urandom, $urandom};
      else k = 64'd1 << $urandom_range(0, 63);
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        k = '0;
        r = mst_pkg::req_t'(2'($urandom_range(0, 3)));
      end else if (sel < 7) begin
        r = mst_pkg::REQ_NONE;
      end else begin
        live++;
        if (r == mst_pkg::REQ_SET && $urandom_range(0, 9) == 0) begin
          k = last_set_key;
          p = last_set_ppm;
        end
        if (r == mst_pkg::REQ_SET) begin
          last_set_key = k;
          last_set_ppm = p;
        end
        drain = (live == 600 || live == 1300);
      end
      if ((n / 150) % 4 == 3) gap = 0;
      else gap = rand_gap();
      push_word(r, k, p, gap, drain);
      n++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (word_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("tb_mru_site_table_with_correction: PASS");
    end else begin
      $display("tb_mru_site_table_with_correction: FAIL");
    end
    $finish;
  end

endmodule
